// File: rtl/fdps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdps_pkg
// Types, constants and fixed-point helpers shared by the film development
// pixel step block.
// ----------------------------------------------------------------------------
package fdps_pkg;

  localparam int unsigned WORD_W      = 32;
  localparam int unsigned PROD_W      = 2 * WORD_W;
  localparam int unsigned NUM_LANES   = 3;
  localparam int unsigned LANE_STAGES = 7;
  localparam int unsigned NUM_STAGES  = LANE_STAGES + 1;
  localparam int unsigned CFG_IDX_W   = 2;

  typedef logic [WORD_W-1:0] word_t;

  localparam word_t WORD_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GROWTH_RATE    = 2'd0,
    REG_DEVELOPER_RATE = 2'd1,
    REG_SALT_RATE      = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    word_t growth_rate;
    word_t developer_rate;
    word_t salt_rate;
  } cfg_regs_t;

  typedef struct packed {
    word_t radius_red;
    word_t radius_green;
    word_t radius_blue;
    word_t active_red;
    word_t active_green;
    word_t active_blue;
    word_t salt_red;
    word_t salt_green;
    word_t salt_blue;
    word_t developer_level;
  } in_payload_t;

  typedef struct packed {
    word_t new_radius_red;
    word_t new_radius_green;
    word_t new_radius_blue;
    word_t new_salt_red;
    word_t new_salt_green;
    word_t new_salt_blue;
    word_t new_developer_level;
  } out_payload_t;

  typedef struct packed {
    word_t radius;
    word_t active;
    word_t salt;
  } lane_in_t;

  typedef struct packed {
    word_t new_radius;
    word_t new_salt;
  } lane_res_t;

  // Full product, truncated by the fraction width, saturated to one word.
  function automatic word_t fx_mul(input word_t a, input word_t b, input int unsigned frac);
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] shifted;
    prod    = PROD_W'(a) * PROD_W'(b);
    shifted = prod >> frac;
    return (|shifted[PROD_W-1:WORD_W]) ? WORD_MAX : shifted[WORD_W-1:0];
  endfunction

  function automatic word_t sat_add(input word_t a, input word_t b);
    logic [WORD_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[WORD_W] ? WORD_MAX : sum[WORD_W-1:0];
  endfunction

  function automatic word_t floor_sub(input word_t a, input word_t b);
    return (b >= a) ? '0 : word_t'(a - b);
  endfunction

endpackage

// File: rtl/fdps_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdps_in_if / fdps_out_if
// Valid/ready channels for pixel items and step results.
// ----------------------------------------------------------------------------
interface fdps_in_if;
  import fdps_pkg::*;

  logic        valid;
  logic        ready;
  in_payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface fdps_out_if;
  import fdps_pkg::*;

  logic         valid;
  logic         ready;
  out_payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/fdps_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdps_lane
// One colour channel: radius growth, volume growth and salt reduction as a
// chain of fixed-point multipliers, one per pipeline stage but the last.
// ----------------------------------------------------------------------------
module fdps_lane #(
  parameter int unsigned FRAC_BITS = 24
) (
  input  logic                               clk,
  input  logic [fdps_pkg::LANE_STAGES-1:0]   en,
  input  fdps_pkg::lane_in_t                 lane_in,
  input  fdps_pkg::word_t                    dev,
  input  fdps_pkg::word_t                    growth_rate,
  input  fdps_pkg::word_t                    salt_rate,
  output fdps_pkg::word_t                    dv,
  output fdps_pkg::lane_res_t                res
);
  import fdps_pkg::*;

  word_t     p1_r, dr_r, p3_r, p4_r, dv_r, sv_r;
  word_t     rad0_r, rad1_r, rad2_r;
  word_t     act0_r, act1_r, act2_r, act3_r;
  word_t     salt0_r, salt1_r, salt2_r, salt3_r, salt4_r, salt5_r;
  word_t     nrad2_r, nrad3_r, nrad4_r, nrad5_r;
  lane_res_t res_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      p1_r    <= fx_mul(dev, lane_in.salt, FRAC_BITS);
      rad0_r  <= lane_in.radius;
      act0_r  <= lane_in.active;
      salt0_r <= lane_in.salt;
    end
    if (en[1]) begin
      dr_r    <= fx_mul(p1_r, growth_rate, FRAC_BITS);
      rad1_r  <= rad0_r;
      act1_r  <= act0_r;
      salt1_r <= salt0_r;
    end
    if (en[2]) begin
      p3_r    <= fx_mul(dr_r, rad1_r, FRAC_BITS);
      nrad2_r <= sat_add(rad1_r, dr_r);
      rad2_r  <= rad1_r;
      act2_r  <= act1_r;
      salt2_r <= salt1_r;
    end
    if (en[3]) begin
      p4_r    <= fx_mul(p3_r, rad2_r, FRAC_BITS);
      nrad3_r <= nrad2_r;
      act3_r  <= act2_r;
      salt3_r <= salt2_r;
    end
    if (en[4]) begin
      dv_r    <= fx_mul(p4_r, act3_r, FRAC_BITS);
      nrad4_r <= nrad3_r;
      salt4_r <= salt3_r;
    end
    if (en[5]) begin
      sv_r    <= fx_mul(salt_rate, dv_r, FRAC_BITS);
      nrad5_r <= nrad4_r;
      salt5_r <= salt4_r;
    end
    if (en[6]) begin
      res_r.new_salt   <= floor_sub(salt5_r, sv_r);
      res_r.new_radius <= nrad5_r;
    end
  end

  assign dv  = dv_r;
  assign res = res_r;

endmodule

// File: rtl/fdps_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdps_merge
// Sums the lane volumes, consumes developer and assembles the result word.
// ----------------------------------------------------------------------------
module fdps_merge #(
  parameter int unsigned FRAC_BITS = 24
) (
  input  logic                              clk,
  input  logic [fdps_pkg::NUM_STAGES-1:0]   en,
  input  fdps_pkg::word_t                   dev,
  input  fdps_pkg::word_t                   developer_rate,
  input  fdps_pkg::word_t                   dv  [fdps_pkg::NUM_LANES],
  input  fdps_pkg::lane_res_t               res [fdps_pkg::NUM_LANES],
  output fdps_pkg::out_payload_t            result
);
  import fdps_pkg::*;

  word_t        dev_r [LANE_STAGES];
  word_t        vsum_r;
  word_t        dd_r;
  out_payload_t out_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      dev_r[0] <= dev;
    end
    for (int k = 1; k < LANE_STAGES; k++) begin
      if (en[k]) begin
        dev_r[k] <= dev_r[k-1];
      end
    end
    if (en[5]) begin
      vsum_r <= sat_add(sat_add(dv[0], dv[1]), dv[2]);
    end
    if (en[6]) begin
      dd_r <= fx_mul(developer_rate, vsum_r, FRAC_BITS);
    end
    if (en[7]) begin
      out_r.new_radius_red      <= res[0].new_radius;
      out_r.new_radius_green    <= res[1].new_radius;
      out_r.new_radius_blue     <= res[2].new_radius;
      out_r.new_salt_red        <= res[0].new_salt;
      out_r.new_salt_green      <= res[1].new_salt;
      out_r.new_salt_blue       <= res[2].new_salt;
      out_r.new_developer_level <= floor_sub(dev_r[LANE_STAGES-1], dd_r);
    end
  end

  assign result = out_r;

endmodule

// File: rtl/film_development_pixel_step_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// film_development_pixel_step_top
// One development time step for one pixel, three colour lanes in parallel.
// ----------------------------------------------------------------------------
// Takes one pixel per clock unless stalled. Each colour lane is a chain of
// six 32x32 fixed-point multipliers, one per stage but the last; the merge
// then sums the three volume growths, multiplies by the developer rate and
// subtracts. Stages advance independently, so bubbles collapse and new pixels
// are still taken while a result waits at the output until the pipeline is
// full. Rate registers are for the user to write only while idle (unchecked).
// ----------------------------------------------------------------------------
module film_development_pixel_step_top #(
  parameter int unsigned FRAC_BITS = 24
) (
  input  logic                              clk,
  input  logic                              rst_n,
  fdps_in_if.sink                           in_ch,
  fdps_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [fdps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  fdps_pkg::word_t                   cfg_wdata
);
  import fdps_pkg::*;

  cfg_regs_t               cfg_r;
  logic [NUM_STAGES-1:0]   v_r;
  logic [NUM_STAGES-1:0]   v_nxt;
  logic [NUM_STAGES-1:0]   en;
  lane_in_t                lane_in  [NUM_LANES];
  word_t                   lane_dv  [NUM_LANES];
  lane_res_t               lane_res [NUM_LANES];
  out_payload_t            result;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_GROWTH_RATE:    cfg_r.growth_rate    <= cfg_wdata;
        REG_DEVELOPER_RATE: cfg_r.developer_rate <= cfg_wdata;
        REG_SALT_RATE:      cfg_r.salt_rate      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    en[NUM_STAGES-1] = !v_r[NUM_STAGES-1] || out_ch.ready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
    v_nxt[0] = en[0] ? in_ch.valid : v_r[0];
    for (int k = 1; k < NUM_STAGES; k++) begin
      v_nxt[k] = en[k] ? v_r[k-1] : v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ch.ready    = en[0];
  assign out_ch.valid   = v_r[NUM_STAGES-1];
  assign out_ch.payload = result;

  assign lane_in[0] = '{radius: in_ch.payload.radius_red,
                        active: in_ch.payload.active_red,
                        salt:   in_ch.payload.salt_red};
  assign lane_in[1] = '{radius: in_ch.payload.radius_green,
                        active: in_ch.payload.active_green,
                        salt:   in_ch.payload.salt_green};
  assign lane_in[2] = '{radius: in_ch.payload.radius_blue,
                        active: in_ch.payload.active_blue,
                        salt:   in_ch.payload.salt_blue};

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    fdps_lane #(
      .FRAC_BITS   (FRAC_BITS)
    ) u_lane (
      .clk         (clk),
      .en          (en[LANE_STAGES-1:0]),
      .lane_in     (lane_in[g]),
      .dev         (in_ch.payload.developer_level),
      .growth_rate (cfg_r.growth_rate),
      .salt_rate   (cfg_r.salt_rate),
      .dv          (lane_dv[g]),
      .res         (lane_res[g])
    );
  end

  fdps_merge #(
    .FRAC_BITS      (FRAC_BITS)
  ) u_merge (
    .clk            (clk),
    .en             (en),
    .dev            (in_ch.payload.developer_level),
    .developer_rate (cfg_r.developer_rate),
    .dv             (lane_dv),
    .res            (lane_res),
    .result         (result)
  );

  // full pipeline with a stalled output must refuse new transfers
  a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (&v_r && !out_ch.ready) |-> !in_ch.ready)
    else $error("input taken while pipeline full and output stalled");

  // an accepted transfer occupies the first stage next cycle
  a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> v_r[0])
    else $error("accepted transfer lost at first stage");

  // the second-to-last stage, if it held data and was not enabled, keeps it
  a_stalled_last_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[NUM_STAGES-2] && !en[NUM_STAGES-2]) |=> v_r[NUM_STAGES-2])
    else $error("stalled stage dropped its item");

endmodule
